>>> src/selective_repeat_tx_scoreboard_macros.svh
// Assertion helpers shared by the scoreboard RTL.
`ifndef SELECTIVE_REPEAT_TX_SCOREBOARD_MACROS_SVH
`define SELECTIVE_REPEAT_TX_SCOREBOARD_MACROS_SVH

// Implication checked in the same cycle.
`define SRTX_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scoreboard check failed");

// Implication checked in the next cycle.
`define SRTX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scoreboard check failed");

`endif

>>> src/srtx_pkg.sv
package srtx_pkg;

   localparam int WINDOW_DEPTH_DEF = 256;
   localparam int SEQ_W            = 32;
   localparam int PAY_W            = 32;
   localparam int IN_WINDOW_W      = 9;

   typedef enum logic [1:0] {
      CMD_SEND  = 2'd0,
      CMD_ACK   = 2'd1,
      CMD_SACK  = 2'd2,
      CMD_QUERY = 2'd3
   } srtx_cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_SACK  = 2'd2,
      STATUS_FULL  = 2'd3
   } srtx_status_type;

   typedef enum logic [1:0] {
      ST_UNDEF = 2'd0,
      ST_UNACK = 2'd1,
      ST_NACK  = 2'd2,
      ST_ACK   = 2'd3
   } srtx_entry_type;

   typedef struct packed {
      srtx_cmd_type     cmd;
      logic [SEQ_W-1:0] seq;
      logic [SEQ_W-1:0] exp_seq;
      logic [PAY_W-1:0] payload_size;
   } srtx_req_type;

   typedef struct packed {
      srtx_status_type        status;
      srtx_entry_type         entry_state;
      logic [PAY_W-1:0]       entry_payload;
      logic [SEQ_W-1:0]       base_seq_out;
      logic [SEQ_W-1:0]       next_seq_out;
      logic [IN_WINDOW_W-1:0] in_window;
   } srtx_rsp_type;

endpackage

>>> src/srtx_ram.sv
module srtx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/selective_repeat_tx_scoreboard.sv
// Selective-repeat transmit scoreboard.
// req_* channel (valid/ready) carries one command transaction: send, ack,
// selective ack or query. rsp_* channel (valid/ready) returns exactly one
// result transaction per command with status, queried entry and the window
// base, next sequence and fill after the command.
// One command is processed at a time; req_ready is high only while the
// sequencer is idle. Steps from the accepting edge until rsp_valid rises:
//   send, out-of-range or below-base commands: evaluate
//   query in window, sack of an entry that is not unacked: evaluate, read
//   ack in window: evaluate and mark acked, then slide the base
//   sack of an unacked entry: evaluate, read and mark acked, nack walk
//   with a read and a write per entry, then slide until an unacked entry or empty.
// Worst case walks and slides the whole window. req_ready rises in the same
// cycle as rsp_valid, once the result is in the output register.
// Entry state and payload live in two RAMs with registered reads; every
// walk step is one read then one write. While the receiver stalls, the
// result waits in the output register; the next command is taken and held
// finished until the register frees. Synchronous reset empties the window
// (base 0, fill 0); RAM contents are not cleared since only sent entries
// are ever read.
module selective_repeat_tx_scoreboard
   import srtx_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  srtx_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output srtx_rsp_type rsp_payload
);

`include "selective_repeat_tx_scoreboard_macros.svh"

   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam int OCC_W = $clog2(WINDOW_DEPTH + 1);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_EVAL = 9'b000000010,
      S_QRD  = 9'b000000100,
      S_SRD  = 9'b000001000,
      S_MRD  = 9'b000010000,
      S_MWR  = 9'b000100000,
      S_SLRD = 9'b001000000,
      S_SLCK = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

   // ring slot of head + offset
   function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (IDX_W+1)'(WINDOW_DEPTH)) begin
         s = s - (IDX_W+1)'(WINDOW_DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   state_type        state_ff, state_in;
   srtx_req_type     req_ff, req_in;
   logic [SEQ_W-1:0] base_ff, base_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   srtx_status_type  status_ff, status_in;
   srtx_entry_type   qstate_ff, qstate_in;
   logic [PAY_W-1:0] qpay_ff, qpay_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] end_ff, end_in;
   logic             rsp_valid_ff, rsp_valid_in;
   srtx_rsp_type     rsp_ff, rsp_in;

   logic             st_wr_en, pay_wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   srtx_entry_type   st_wr_data;
   logic [1:0]       st_rd_data;
   logic [PAY_W-1:0] pay_rd_data;

   logic [SEQ_W-1:0] next_seq;
   logic             below, beyond, exp_ok;
   logic [IDX_W-1:0] off, tgt, send_slot, walk_slot;

   // shared offset / compare unit
   always_comb begin
      next_seq  = base_ff + SEQ_W'(occ_ff);
      below     = req_ff.seq < base_ff;
      beyond    = req_ff.seq >= next_seq;
      exp_ok    = (req_ff.exp_seq >= base_ff) && (req_ff.exp_seq <= req_ff.seq);
      off       = IDX_W'(req_ff.seq - base_ff);
      tgt       = slot_add(head_ff, off);
      send_slot = slot_add(head_ff, IDX_W'(occ_ff));
      walk_slot = slot_add(head_ff, idx_ff);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      base_in      = base_ff;
      head_in      = head_ff;
      occ_in       = occ_ff;
      status_in    = status_ff;
      qstate_in    = qstate_ff;
      qpay_in      = qpay_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      st_wr_en     = 1'b0;
      pay_wr_en    = 1'b0;
      wr_addr      = slot_ff;
      st_wr_data   = ST_ACK;
      rd_addr      = tgt;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_payload;
               status_in = STATUS_OK;
               qstate_in = ST_UNDEF;
               qpay_in   = '0;
               state_in  = S_EVAL;
            end
         end
         S_EVAL: begin
            slot_in = tgt;
            end_in  = off;
            unique case (req_ff.cmd)
               CMD_SEND: begin
                  if (occ_ff >= OCC_W'(WINDOW_DEPTH) || next_seq == '1) begin
                     status_in = STATUS_FULL;
                  end else begin
                     st_wr_en   = 1'b1;
                     pay_wr_en  = 1'b1;
                     wr_addr    = send_slot;
                     st_wr_data = ST_UNACK;
                     occ_in     = occ_ff + 1'b1;
                  end
                  state_in = S_DONE;
               end
               CMD_ACK: begin
                  if (beyond) begin
                     status_in = STATUS_RANGE;
                     state_in  = S_DONE;
                  end else if (below) begin
                     state_in = S_DONE;
                  end else begin
                     st_wr_en = 1'b1;
                     wr_addr  = tgt;
                     state_in = S_SLRD;
                  end
               end
               CMD_SACK: begin
                  if (beyond) begin
                     status_in = STATUS_RANGE;
                     state_in  = S_DONE;
                  end else if (below) begin
                     status_in = STATUS_SACK;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_SRD;
                  end
               end
               CMD_QUERY: begin
                  if (beyond) begin
                     status_in = STATUS_RANGE;
                     state_in  = S_DONE;
                  end else if (below) begin
                     status_in = STATUS_RANGE;
                     qstate_in = ST_ACK;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_QRD;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_QRD: begin
            qstate_in = srtx_entry_type'(st_rd_data);
            qpay_in   = pay_rd_data;
            state_in  = S_DONE;
         end
         S_SRD: begin
            if (st_rd_data != ST_UNACK) begin
               status_in = STATUS_SACK;
               state_in  = S_DONE;
            end else begin
               st_wr_en = 1'b1;
               idx_in   = IDX_W'(req_ff.exp_seq - base_ff);
               if (exp_ok && IDX_W'(req_ff.exp_seq - base_ff) < end_ff) begin
                  state_in = S_MRD;
               end else begin
                  state_in = S_SLRD;
               end
            end
         end
         // nack walk: read, then conditional write
         S_MRD: begin
            rd_addr  = walk_slot;
            state_in = S_MWR;
         end
         S_MWR: begin
            wr_addr    = walk_slot;
            st_wr_data = ST_NACK;
            st_wr_en   = (st_rd_data == ST_UNACK);
            idx_in     = idx_ff + 1'b1;
            state_in   = (idx_ff + 1'b1 == end_ff) ? S_SLRD : S_MRD;
         end
         // slide base over leading acked entries
         S_SLRD: begin
            rd_addr  = head_ff;
            state_in = (occ_ff == '0) ? S_DONE : S_SLCK;
         end
         S_SLCK: begin
            if (st_rd_data == ST_ACK) begin
               head_in  = (head_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               base_in  = base_ff + 1'b1;
               occ_in   = occ_ff - 1'b1;
               state_in = S_SLRD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = status_ff;
               rsp_in.entry_state   = qstate_ff;
               rsp_in.entry_payload = qpay_ff;
               rsp_in.base_seq_out  = base_ff;
               rsp_in.next_seq_out  = next_seq;
               rsp_in.in_window     = IN_WINDOW_W'(occ_ff);
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      status_ff <= status_in;
      qstate_ff <= qstate_in;
      qpay_ff   <= qpay_in;
      slot_ff   <= slot_in;
      idx_ff    <= idx_in;
      end_ff    <= end_in;
      rsp_ff    <= rsp_in;
   end

   // entry storage
   srtx_ram #(.WIDTH(2), .DEPTH(WINDOW_DEPTH)) u_state_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (rd_addr),
      .rd_data (st_rd_data)
   );

   srtx_ram #(.WIDTH(PAY_W), .DEPTH(WINDOW_DEPTH)) u_pay_ram (
      .clock   (clock),
      .wr_en   (pay_wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ff.payload_size),
      .rd_addr (rd_addr),
      .rd_data (pay_rd_data)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SRTX_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, occ_ff <= OCC_W'(WINDOW_DEPTH))
   `SRTX_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `SRTX_ASSERT_NOW(a_base_monotonic, clock, reset, !$past(reset), base_ff >= $past(base_ff))
   `SRTX_ASSERT_NOW(a_walk_in_range, clock, reset, state_ff == S_MRD, idx_ff < end_ff)

endmodule
